// ===== rtl/ssb_pkg.sv =====
// Shared types, constants and helper functions for the scaled sprite blitter.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssb_pkg;

    localparam int MAX_TEXELS_DEF  = 16384;
    localparam int MAX_FB_SIDE_DEF = 2048;
    localparam int DIV_STEPS       = 16;
    localparam int FIFO_DEPTH      = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic FMT_BGRA8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [3:0] {
        CFG_SOURCE_ORIGIN = 4'd0,
        CFG_SOURCE_SIZE   = 4'd1,
        CFG_DEST_ORIGIN   = 4'd2,
        CFG_DEST_SIZE     = 4'd3,
        CFG_COLOR_GAIN    = 4'd4,
        CFG_FRAME_SIZE    = 4'd5,
        CFG_SPRITE_STRIDE = 4'd6,
        CFG_PIXEL_FORMAT  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] source_origin;
        logic [31:0] source_size;
        logic [31:0] dest_origin;
        logic [31:0] dest_size;
        logic [23:0] color_gain;
        logic [27:0] frame_size;
        logic [14:0] sprite_stride;
        logic        pixel_format;
    } t_cfg;

    // Item state carried alongside the divider stages
    typedef struct packed {
        logic        op;
        logic        sup;
        logic [13:0] ti;
        logic [31:0] tv;
        logic [21:0] addr;
    } t_tag;

    // Queue entry between front and back
    typedef struct packed {
        t_tag        tag;
        logic [31:0] nx;
        logic [31:0] ny;
    } t_work;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] low;
        logic [15:0] q;
    } t_dstep;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic t_dstep div_step(input t_dstep s, input logic [15:0] d);
        logic [16:0] t;
        logic        ge;
        t_dstep      o;
        t = {s.rem, s.low[15]};
        ge = (t >= {1'b0, d});
        o.rem = ge ? 16'(t - {1'b0, d}) : t[15:0];
        o.low = {s.low[14:0], 1'b0};
        o.q = {s.q[14:0], ge};
        return o;
    endfunction

    // Exact floor(x/255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssb_fifo.sv =====
// Short work queue between the front and back of the blitter.
// Depends on ssb_pkg (t_work, FIFO_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module ssb_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  ssb_pkg::t_work i_data,
    input  wire            i_pop,
    output ssb_pkg::t_work o_data,
    output logic           o_full,
    output logic           o_empty
);
    import ssb_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_work           r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 $past(i_rst_n) |->
        r_cnt == $past(r_cnt) + (PW+1)'($past(i_push)) - (PW+1)'($past(i_pop)))
        else $error("queue count out of step");

endmodule

`default_nettype wire

// ===== rtl/ssb_front.sv =====
// Front end: accepts items, checks rectangle and framebuffer bounds,
// forms the framebuffer address and the scaling products. Depends on ssb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssb_front #(
    parameter int MAX_FB_SIDE = ssb_pkg::MAX_FB_SIDE_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ssb_pkg::t_cfg  i_cfg,
    input  wire            i_valid,
    output logic           o_stall,
    input  wire            i_op,
    input  wire [13:0]     i_texel_index,
    input  wire [31:0]     i_texel_value,
    input  wire [15:0]     i_column,
    input  wire [15:0]     i_row,
    output logic           o_push,
    output ssb_pkg::t_work o_work,
    input  wire            i_full
);
    import ssb_pkg::*;

    localparam int FW = $clog2(MAX_FB_SIDE + 1);

    logic        r_fv;
    logic        r_op;
    logic [13:0] r_ti;
    logic [31:0] r_tv;
    logic [15:0] r_col;
    logic [15:0] r_row;

    logic          take;
    logic [FW-1:0] fbw;
    logic [FW-1:0] fbh;
    logic [17:0]   fx;
    logic [17:0]   fy;
    logic          out_rect;
    logic          out_fb;

    assign o_stall = r_fv && i_full;
    assign take    = i_valid && !o_stall;
    assign o_push  = r_fv && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (take) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op  <= i_op;
            r_ti  <= i_texel_index;
            r_tv  <= i_texel_value;
            r_col <= i_column;
            r_row <= i_row;
        end
    end

    always_comb begin
        fbw = (32'(i_cfg.frame_size[11:0]) > 32'(MAX_FB_SIDE)) ?
              FW'(MAX_FB_SIDE) : FW'(i_cfg.frame_size[11:0]);
        fbh = (32'(i_cfg.frame_size[27:16]) > 32'(MAX_FB_SIDE)) ?
              FW'(MAX_FB_SIDE) : FW'(i_cfg.frame_size[27:16]);
        fx = {{2{i_cfg.dest_origin[15]}}, i_cfg.dest_origin[15:0]} + {2'b00, r_col};
        fy = {{2{i_cfg.dest_origin[31]}}, i_cfg.dest_origin[31:16]} + {2'b00, r_row};
        out_rect = (r_col >= i_cfg.dest_size[15:0]) || (r_row >= i_cfg.dest_size[31:16]);
        // columns and rows left of or above the framebuffer are dropped, not shifted
        out_fb = fx[17] || fy[17] || (fx[16:0] >= 17'(fbw)) || (fy[16:0] >= 17'(fbh));

        o_work.tag.op   = r_op;
        o_work.tag.sup  = out_rect || out_fb;
        o_work.tag.ti   = r_ti;
        o_work.tag.tv   = r_tv;
        o_work.tag.addr = 22'(32'(fy[16:0]) * 32'(fbw) + 32'(fx[16:0]));
        o_work.nx       = r_col * i_cfg.source_size[15:0];
        o_work.ny       = r_row * i_cfg.source_size[31:16];
    end

endmodule

`default_nettype wire

// ===== rtl/ssb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for a divisor that
// holds steady while items flow. Depends on ssb_pkg (t_dstep, div_step).
`timescale 1ns / 1ps
`default_nettype none

module ssb_div (
    input  wire         i_clk,
    input  wire         i_en,
    input  wire [31:0]  i_num,
    input  wire [15:0]  i_den,
    output logic [15:0] o_quot
);
    import ssb_pkg::*;

    t_dstep r_st [DIV_STEPS];
    t_dstep init;

    // quotient fits 16 bits because column < width, so the top half is below the divisor
    assign init   = '{rem: i_num[31:16], low: i_num[15:0], q: 16'd0};
    assign o_quot = r_st[DIV_STEPS-1].q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(init, i_den);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_st[k] <= div_step(r_st[k-1], i_den);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssb_back.sv =====
// Back end: scaling division, texel index, sprite store, colour gain and packing.
// Depends on ssb_pkg and ssb_div.
`timescale 1ns / 1ps
`default_nettype none

module ssb_back #(
    parameter int MAX_TEXELS = ssb_pkg::MAX_TEXELS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ssb_pkg::t_cfg  i_cfg,
    input  ssb_pkg::t_work i_work,
    input  wire            i_work_valid,
    output logic           o_pop,
    output logic           o_valid,
    input  wire            i_stall,
    output logic           o_write_enable,
    output logic [21:0]    o_fb_address,
    output logic [31:0]    o_pixel_value
);
    import ssb_pkg::*;

    localparam int AW = $clog2(MAX_TEXELS);

    logic adv;

    logic        r_tv  [DIV_STEPS];
    t_tag        r_tag [DIV_STEPS];
    logic [15:0] qx;
    logic [15:0] qy;

    logic        r_iv;
    t_tag        r_itag;
    logic [32:0] r_idx;
    logic        idx_in;

    logic        r_mv;
    logic        r_mdraw;
    logic [21:0] r_maddr;
    logic [31:0] r_tex;

    logic        r_cv;
    logic        r_cwe;
    logic [21:0] r_caddr;
    logic [15:0] r_pr;
    logic [15:0] r_pg;
    logic [15:0] r_pb;

    logic        r_ov;
    logic        r_we;
    logic [21:0] r_addr;
    logic [31:0] r_pix;

    logic [31:0] mem [MAX_TEXELS];

    logic [16:0] sx;
    logic [16:0] sy;
    logic [32:0] idx_d;
    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;
    logic [31:0] pix;

    // the whole back pipeline moves when the output slot is free or being taken
    assign adv   = !r_ov || !i_stall;
    assign o_pop = adv && i_work_valid;

    ssb_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (i_work.nx),
        .i_den  (i_cfg.dest_size[15:0]),
        .o_quot (qx)
    );

    ssb_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (i_work.ny),
        .i_den  (i_cfg.dest_size[31:16]),
        .o_quot (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_tv[k] <= 1'b0;
            r_iv <= 1'b0;
            r_mv <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_tv[0] <= i_work_valid;
            for (int k = 1; k < DIV_STEPS; k++) r_tv[k] <= r_tv[k-1];
            r_iv <= r_tv[DIV_STEPS-1];
            r_mv <= r_iv;
            r_cv <= r_mv;
            r_ov <= r_cv;
        end
    end

    always_comb begin
        sx = 17'(i_cfg.source_origin[15:0]) + 17'(qx);
        sy = 17'(i_cfg.source_origin[31:16]) + 17'(qy);
        if (r_tag[DIV_STEPS-1].op == OP_LOAD) begin
            idx_d = 33'(r_tag[DIV_STEPS-1].ti);
        end else begin
            idx_d = 33'(32'(sy) * 32'(i_cfg.sprite_stride)) + 33'(sx);
        end
    end

    assign idx_in = (r_idx < 33'(MAX_TEXELS));

    always_comb begin
        cr = div255(r_pr);
        cg = div255(r_pg);
        cb = div255(r_pb);
        if (i_cfg.pixel_format == FMT_RGB565) begin
            pix = {16'd0, cr[7:3], cg[7:2], cb[7:3]};
        end else begin
            pix = {8'hFF, cr, cg, cb};
        end
    end

    // store is written and read at the same stage so loads and draws stay in order
    always_ff @(posedge i_clk) begin
        if (adv && r_iv && idx_in) begin
            if (r_itag.op == OP_LOAD) begin
                mem[r_idx[AW-1:0]] <= r_itag.tv;
            end else begin
                r_tex <= mem[r_idx[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[0] <= i_work.tag;
            for (int k = 1; k < DIV_STEPS; k++) r_tag[k] <= r_tag[k-1];

            r_itag <= r_tag[DIV_STEPS-1];
            r_idx  <= idx_d;

            r_mdraw <= (r_itag.op == OP_DRAW) && !r_itag.sup && idx_in;
            r_maddr <= r_itag.addr;

            r_cwe   <= r_mdraw && (r_tex[31:24] == ALPHA_OPAQUE);
            r_caddr <= r_maddr;
            r_pr    <= r_tex[7:0] * i_cfg.color_gain[7:0];
            r_pg    <= r_tex[15:8] * i_cfg.color_gain[15:8];
            r_pb    <= r_tex[23:16] * i_cfg.color_gain[23:16];

            r_we   <= r_cwe;
            r_addr <= r_cwe ? r_caddr : 22'd0;
            r_pix  <= r_cwe ? pix : 32'd0;
        end
    end

    assign o_valid        = r_ov;
    assign o_write_enable = r_we;
    assign o_fb_address   = r_addr;
    assign o_pixel_value  = r_pix;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_pix) && $stable(r_we))
        else $error("result changed while stalled");
    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_we |-> r_addr == 22'd0 && r_pix == 32'd0)
        else $error("suppressed result not zero");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |-> !o_pop) else $error("queue popped while output stalled");

endmodule

`default_nettype wire

// ===== rtl/scaled_sprite_blit.sv =====
// Top level of the scaled sprite blitter: configuration registers, front end,
// work queue and back end. Depends on ssb_pkg, ssb_front, ssb_fifo, ssb_back.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  input    | i_valid / o_stall       | i_op i_texel_index i_texel_value i_column i_row
//  output   | o_valid / i_stall       | o_write_enable o_fb_address o_pixel_value
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
//  One item per clock sustained while the output is not stalled; the path runs
//  through the 16-stage restoring dividers (one quotient bit per stage) and the store read.
//  Every item, load or draw, yields exactly one result transaction.
//  Reset is synchronous, active low; the sprite store is not cleared.
//  An output stall holds the whole back pipeline; the queue then fills and
//  the input stalls once the queue and the front register are both full.

module scaled_sprite_blit #(
    parameter int MAX_TEXELS  = ssb_pkg::MAX_TEXELS_DEF,
    parameter int MAX_FB_SIDE = ssb_pkg::MAX_FB_SIDE_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_op,
    input  wire [13:0]  i_texel_index,
    input  wire [31:0]  i_texel_value,
    input  wire [15:0]  i_column,
    input  wire [15:0]  i_row,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_write_enable,
    output logic [21:0] o_fb_address,
    output logic [31:0] o_pixel_value,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [3:0]   i_cfg_index,
    input  wire [31:0]  i_cfg_data
);
    import ssb_pkg::*;

    t_cfg  r_cfg;
    t_work push_data;
    t_work pop_data;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_origin <= 32'd0;
            r_cfg.source_size   <= 32'h0001_0001;
            r_cfg.dest_origin   <= 32'd0;
            r_cfg.dest_size     <= 32'h0001_0001;
            r_cfg.color_gain    <= 24'hFF_FFFF;
            r_cfg.frame_size    <= 28'd0;
            r_cfg.sprite_stride <= 15'd1;
            r_cfg.pixel_format  <= FMT_BGRA8888;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_ORIGIN: r_cfg.source_origin <= i_cfg_data;
                CFG_SOURCE_SIZE:   r_cfg.source_size   <= i_cfg_data;
                CFG_DEST_ORIGIN:   r_cfg.dest_origin   <= i_cfg_data;
                CFG_DEST_SIZE:     r_cfg.dest_size     <= i_cfg_data;
                CFG_COLOR_GAIN:    r_cfg.color_gain    <= i_cfg_data[23:0];
                CFG_FRAME_SIZE:    r_cfg.frame_size    <= i_cfg_data[27:0];
                CFG_SPRITE_STRIDE: r_cfg.sprite_stride <= i_cfg_data[14:0];
                CFG_PIXEL_FORMAT:  r_cfg.pixel_format  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ssb_front #(.MAX_FB_SIDE(MAX_FB_SIDE)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_texel_index (i_texel_index),
        .i_texel_value (i_texel_value),
        .i_column      (i_column),
        .i_row         (i_row),
        .o_push        (push),
        .o_work        (push_data),
        .i_full        (full)
    );

    ssb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    ssb_back #(.MAX_TEXELS(MAX_TEXELS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_work         (pop_data),
        .i_work_valid   (!empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_fb_address   (o_fb_address),
        .o_pixel_value  (o_pixel_value)
    );

endmodule

`default_nettype wire
